[sv/btfe_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the BER-TLV field extractor.
// Depends on nothing; imported by ber_tlv_field_extractor_top.
package btfe_pkg;

  localparam int LEN_WIDTH  = 16;
  localparam int IDX_WIDTH  = LEN_WIDTH + 2;
  localparam int HDR_WIDTH  = 3;
  localparam int BYTE_W     = 8;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Length byte forms.
  localparam logic [BYTE_W-1:0] LEN_SHORT_MAX = 8'h7F;
  localparam logic [BYTE_W-1:0] LEN_LONG1     = 8'h81;
  localparam logic [BYTE_W-1:0] LEN_LONG2     = 8'h82;

  // Header sizes for each length form.
  localparam logic [HDR_WIDTH-1:0] HDR_SHORT = 3'd2;
  localparam logic [HDR_WIDTH-1:0] HDR_LONG1 = 3'd3;
  localparam logic [HDR_WIDTH-1:0] HDR_LONG2 = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_TAG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_CAPACITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LEN   = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN,
    PH_LEN1,
    PH_LEN2H,
    PH_LEN2L,
    PH_VALUE
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_TAG    = 3'd1,
    ST_BAD_FORM   = 3'd2,
    ST_OVER_CAP   = 3'd3,
    ST_OVER_BUF   = 3'd4
  } status_t;

endpackage

[sv/ber_tlv_field_extractor_top.sv]
`timescale 1ns / 1ps
// Streaming extractor for one BER-TLV record: tag check, length decode, value copy.
// Depends on btfe_pkg for types, widths and constants.
//
// The block takes one byte per cycle and gives at most one result per byte, so it
// sustains one item per clock. Each byte is decoded by a small next-state and compare
// stage that feeds a single output register; the input is stalled only while that
// register holds a result the downstream side is stalling. Tag and length bytes give
// no result unless they end the record with an error or a zero length; each value
// byte gives one result, and the final one carries last. A byte marked first always
// starts a new record. Configuration writes are always ready and should be made only
// while no record is in flight.
module ber_tlv_field_extractor_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [btfe_pkg::BYTE_W-1:0]          data_byte,
  input  logic                                 first,
  input  logic [btfe_pkg::LEN_WIDTH-1:0]       start_index,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [btfe_pkg::STATUS_W-1:0]        status,
  output logic [btfe_pkg::BYTE_W-1:0]          payload_byte,
  output logic [btfe_pkg::LEN_WIDTH-1:0]       value_len,
  output logic [btfe_pkg::IDX_WIDTH-1:0]       next_index,
  output logic                                 last,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [btfe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [btfe_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import btfe_pkg::*;

  // configuration
  logic [BYTE_W-1:0]    expected_tag;
  logic [LEN_WIDTH-1:0] out_capacity;
  logic [LEN_WIDTH-1:0] buffer_len;

  // record state
  phase_t               phase, phase_next;
  logic [LEN_WIDTH-1:0] remaining_bytes, remaining_bytes_next;
  logic [LEN_WIDTH-1:0] decoded_length, decoded_length_next;
  logic [LEN_WIDTH-1:0] record_start, record_start_next;
  logic [HDR_WIDTH-1:0] header_size, header_size_next;
  logic [IDX_WIDTH-1:0] record_end, record_end_next;

  // decode decisions
  logic                 in_xfer;
  logic                 out_free;
  logic                 len_check;
  logic [LEN_WIDTH-1:0] cand_len;
  logic [HDR_WIDTH-1:0] cand_hdr;
  logic [IDX_WIDTH-1:0] cand_end;
  logic                 fail_en;
  status_t              fail_code;
  logic                 zero_done;
  logic                 value_emit;
  logic [LEN_WIDTH-1:0] remaining_dec;

  // result assembly
  logic                 res_fire;
  status_t              res_status;
  logic [BYTE_W-1:0]    res_byte;
  logic [LEN_WIDTH-1:0] res_len;
  logic [IDX_WIDTH-1:0] res_index;
  logic                 res_last;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = !out_free;
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign remaining_dec = remaining_bytes - {{(LEN_WIDTH-1){1'b0}}, 1'b1};
  assign cand_end = {2'b00, record_start} + {{(IDX_WIDTH-HDR_WIDTH){1'b0}}, cand_hdr}
                  + {2'b00, cand_len};

  // Next state and decode decisions.
  always_comb begin
    phase_next           = phase;
    remaining_bytes_next = remaining_bytes;
    decoded_length_next  = decoded_length;
    record_start_next    = record_start;
    header_size_next     = header_size;
    record_end_next      = record_end;
    len_check            = 1'b0;
    cand_len             = decoded_length;
    cand_hdr             = header_size;
    fail_en              = 1'b0;
    fail_code            = ST_OK;
    zero_done            = 1'b0;
    value_emit           = 1'b0;

    if (in_xfer) begin
      if (first) begin
        record_start_next    = start_index;
        decoded_length_next  = '0;
        header_size_next     = '0;
        remaining_bytes_next = '0;
        if (start_index > buffer_len || data_byte != expected_tag) begin
          fail_en   = 1'b1;
          fail_code = ST_BAD_TAG;
        end else begin
          phase_next = PH_LEN;
        end
      end else begin
        case (phase)
          PH_LEN: begin
            if (data_byte <= LEN_SHORT_MAX) begin
              cand_len         = {{(LEN_WIDTH-BYTE_W){1'b0}}, data_byte};
              cand_hdr         = HDR_SHORT;
              header_size_next = HDR_SHORT;
              len_check        = 1'b1;
            end else if (data_byte == LEN_LONG1) begin
              header_size_next = HDR_LONG1;
              phase_next       = PH_LEN1;
            end else if (data_byte == LEN_LONG2) begin
              header_size_next = HDR_LONG2;
              phase_next       = PH_LEN2H;
            end else begin
              fail_en   = 1'b1;
              fail_code = ST_BAD_FORM;
            end
          end
          PH_LEN1: begin
            cand_len  = {{(LEN_WIDTH-BYTE_W){1'b0}}, data_byte};
            len_check = 1'b1;
          end
          PH_LEN2H: begin
            decoded_length_next = {data_byte, {(LEN_WIDTH-BYTE_W){1'b0}}};
            phase_next          = PH_LEN2L;
          end
          PH_LEN2L: begin
            cand_len  = decoded_length | {{(LEN_WIDTH-BYTE_W){1'b0}}, data_byte};
            len_check = 1'b1;
          end
          PH_VALUE: begin
            value_emit           = 1'b1;
            remaining_bytes_next = remaining_dec;
            if (remaining_dec == '0) begin
              phase_next = PH_IDLE;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end

      // A complete length is checked against capacity first, then the buffer.
      if (len_check) begin
        decoded_length_next = cand_len;
        record_end_next     = cand_end;
        if (cand_len > out_capacity) begin
          fail_en   = 1'b1;
          fail_code = ST_OVER_CAP;
        end else if (cand_len > buffer_len) begin
          fail_en   = 1'b1;
          fail_code = ST_OVER_BUF;
        end else if (cand_len == '0) begin
          zero_done  = 1'b1;
          phase_next = PH_IDLE;
        end else begin
          remaining_bytes_next = cand_len;
          phase_next           = PH_VALUE;
        end
      end

      if (fail_en) begin
        phase_next           = PH_IDLE;
        remaining_bytes_next = '0;
      end
    end
  end

  // Result fields for the byte just taken.
  always_comb begin
    res_fire   = 1'b0;
    res_status = ST_OK;
    res_byte   = '0;
    res_len    = '0;
    res_index  = '0;
    res_last   = 1'b0;
    if (fail_en) begin
      res_fire   = 1'b1;
      res_status = fail_code;
      res_last   = 1'b1;
    end else if (zero_done) begin
      res_fire  = 1'b1;
      res_index = cand_end;
      res_last  = 1'b1;
    end else if (value_emit) begin
      res_fire  = 1'b1;
      res_byte  = data_byte;
      res_len   = decoded_length;
      res_index = record_end;
      res_last  = (remaining_dec == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      remaining_bytes <= '0;
      decoded_length  <= '0;
      record_start    <= '0;
      header_size     <= '0;
      record_end      <= '0;
    end else begin
      phase           <= phase_next;
      remaining_bytes <= remaining_bytes_next;
      decoded_length  <= decoded_length_next;
      record_start    <= record_start_next;
      header_size     <= header_size_next;
      record_end      <= record_end_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_tag <= '0;
      out_capacity <= '1;
      buffer_len   <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_EXPECTED_TAG: expected_tag <= cfg_data[BYTE_W-1:0];
        CFG_OUT_CAPACITY: out_capacity <= cfg_data[LEN_WIDTH-1:0];
        CFG_BUFFER_LEN:   buffer_len   <= cfg_data[LEN_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  // The output register refills whenever the held result has gone or none is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_xfer && res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_xfer && res_fire) begin
      status       <= res_status;
      payload_byte <= res_byte;
      value_len    <= res_len;
      next_index   <= res_index;
      last         <= res_last;
    end
  end

endmodule
